@@ hdl/rcrx_pkg.sv @@
// ----------------------------------------------------------------------------
// rcrx_pkg
// Shared constants and types for the rc receive packet decoder: payload
// layout, header codes and result status codes.
// ----------------------------------------------------------------------------
package rcrx_pkg;

    // payload layout
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned HELD_COUNT = 12;
    localparam int unsigned STICK_W    = 10;
    localparam int unsigned AUX_W      = 7;
    localparam int unsigned ADDR_W     = 40;
    localparam int unsigned HOP_W      = 32;
    localparam int unsigned STATUS_W   = 3;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(14);

    // header and marker bytes
    localparam logic [BYTE_W-1:0] HDR_CONTROL  = 8'd165;
    localparam logic [BYTE_W-1:0] HDR_BIND     = 8'ha4;
    localparam logic [BYTE_W-1:0] HDR_BIND_TLM = 8'ha3;
    localparam logic [BYTE_W-1:0] EXPERT_MARK  = 8'hfa;

    // offset that centers a ten-bit stick value
    localparam logic [STICK_W-1:0] STICK_CENTER = STICK_W'(512);

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_CONTROL   = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_BAD_SUM   = 3'd2,
        ST_BIND_OK   = 3'd3,
        ST_BIND_SKIP = 3'd4
    } status_t;

    typedef logic [BYTE_W-1:0] byte_t;

    // ten-bit value from the low two bits of hi and all of lo
    function automatic logic [STICK_W-1:0] ten_bits(input byte_t hi, input byte_t lo);
        ten_bits = {hi[1:0], lo};
    endfunction

endpackage

@@ hdl/rc_rx_packet_decoder_top.sv @@
// ----------------------------------------------------------------------------
// rc_rx_packet_decoder_top
// Decodes a 15-byte rc receive payload taken one byte per transaction and
// gives one result on the last byte: bind or control decode, or an error.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | byte_value, packet_start
//  out     | out_valid / out_ready| status, roll, pitch, yaw, throttle,
//          |                      | aux_flags, aux_changed, bind_address,
//          |                      | hop_channels, telemetry_on
//
//  one byte per cycle sustained, unless a last byte waits on a full result
//  register; a byte goes input register -> decode -> result register, so
//  a result is valid once its last byte has passed both registers. the
//  result register is the only stall point: a byte that ends no payload
//  moves on even while a result waits. asynchronous reset clears position,
//  sum and aux history and enters bind mode; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rc_rx_packet_decoder_top
    import rcrx_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [BYTE_W-1:0]         byte_value,
    input  logic                      packet_start,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [STATUS_W-1:0]       status,
    output logic signed [STICK_W-1:0] roll,
    output logic signed [STICK_W-1:0] pitch,
    output logic signed [STICK_W-1:0] yaw,
    output logic [STICK_W-1:0]        throttle,
    output logic [AUX_W-1:0]          aux_flags,
    output logic [AUX_W-1:0]          aux_changed,
    output logic [ADDR_W-1:0]         bind_address,
    output logic [HOP_W-1:0]          hop_channels,
    output logic                      telemetry_on
);

    // input register
    logic              in_valid_reg;
    byte_t             in_byte_reg;
    logic              in_start_reg;

    // decoder state
    logic [POS_W-1:0]  pos_reg, pos_next;
    byte_t             sum_reg, sum_next;
    byte_t             held_reg [HELD_COUNT];
    logic              bind_pending_reg, bind_pending_next;
    logic              tlm_reg, tlm_next;
    logic [AUX_W-1:0]  prev_aux_reg, prev_aux_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    status_t            status_reg, status_next;
    logic [STICK_W-1:0] roll_reg, roll_next;
    logic [STICK_W-1:0] pitch_reg, pitch_next;
    logic [STICK_W-1:0] yaw_reg, yaw_next;
    logic [STICK_W-1:0] thr_reg, thr_next;
    logic [AUX_W-1:0]   aux_reg, aux_next;
    logic [AUX_W-1:0]   aux_chg_reg, aux_chg_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [HOP_W-1:0]   hop_reg, hop_next;

    // decode stage control
    logic              out_free;
    logic              is_last;
    logic              proc_fire;
    logic              emit;
    logic [POS_W-1:0]  pos_cur;
    byte_t             sum_cur;
    logic [AUX_W-1:0]  flags;

    // position and sum as seen by the registered byte
    assign pos_cur   = in_start_reg ? '0 : pos_reg;
    assign sum_cur   = in_start_reg ? '0 : sum_reg;
    assign is_last   = (pos_cur >= LAST_POS);
    assign out_free  = !out_valid_reg || out_ready;
    assign proc_fire = in_valid_reg && (out_free || !is_last);
    assign emit      = proc_fire && is_last;
    assign in_ready  = !in_valid_reg || proc_fire;

    // aux flag extraction from held bytes 1 to 3
    assign flags = {(held_reg[1] == EXPERT_MARK), held_reg[3][7], held_reg[2][5],
                    held_reg[2][4], held_reg[2][3], held_reg[2][1], held_reg[2][0]};

    // next state and result
    always_comb
    begin
        pos_next          = pos_reg;
        sum_next          = sum_reg;
        bind_pending_next = bind_pending_reg;
        tlm_next          = tlm_reg;
        prev_aux_next     = prev_aux_reg;
        status_next       = status_reg;
        roll_next         = '0;
        pitch_next        = '0;
        yaw_next          = '0;
        thr_next          = '0;
        aux_next          = '0;
        aux_chg_next      = '0;
        addr_next         = '0;
        hop_next          = '0;

        if (proc_fire)
        begin
            if (!is_last)
            begin
                sum_next = sum_cur + in_byte_reg;
                pos_next = pos_cur + POS_W'(1);
            end
            else
            begin
                // last byte: sum is kept, position wraps
                sum_next = sum_cur;
                pos_next = '0;
                priority if (bind_pending_reg)
                begin
                    if (held_reg[0] == HDR_BIND || held_reg[0] == HDR_BIND_TLM)
                    begin
                        status_next       = ST_BIND_OK;
                        bind_pending_next = 1'b0;
                        if (held_reg[0] == HDR_BIND_TLM)
                        begin
                            tlm_next = 1'b1;
                        end
                        addr_next = {held_reg[5], held_reg[4], held_reg[3],
                                     held_reg[2], held_reg[1]};
                        hop_next  = {held_reg[9], held_reg[8], held_reg[7], held_reg[6]};
                    end
                    else
                    begin
                        status_next = ST_BIND_SKIP;
                    end
                end
                else if (held_reg[0] != HDR_CONTROL)
                begin
                    status_next = ST_BAD_HDR;
                end
                else if (sum_cur != in_byte_reg)
                begin
                    status_next = ST_BAD_SUM;
                end
                else
                begin
                    status_next   = ST_CONTROL;
                    roll_next     = ten_bits(held_reg[4], held_reg[5]) + STICK_CENTER;
                    pitch_next    = ten_bits(held_reg[6], held_reg[7]) + STICK_CENTER;
                    yaw_next      = ten_bits(held_reg[10], held_reg[11]) + STICK_CENTER;
                    thr_next      = ten_bits(held_reg[8], held_reg[9]);
                    aux_next      = flags;
                    aux_chg_next  = flags ^ prev_aux_reg;
                    prev_aux_next = flags;
                end
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            pos_reg          <= '0;
            sum_reg          <= '0;
            bind_pending_reg <= 1'b1;
            tlm_reg          <= 1'b0;
            prev_aux_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            pos_reg          <= pos_next;
            sum_reg          <= sum_next;
            bind_pending_reg <= bind_pending_next;
            tlm_reg          <= tlm_next;
            prev_aux_reg     <= prev_aux_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg  <= byte_value;
            in_start_reg <= packet_start;
        end
        if (proc_fire && (pos_cur < POS_W'(HELD_COUNT)))
        begin
            held_reg[pos_cur] <= in_byte_reg;
        end
        if (emit)
        begin
            status_reg  <= status_next;
            roll_reg    <= roll_next;
            pitch_reg   <= pitch_next;
            yaw_reg     <= yaw_next;
            thr_reg     <= thr_next;
            aux_reg     <= aux_next;
            aux_chg_reg <= aux_chg_next;
            addr_reg    <= addr_next;
            hop_reg     <= hop_next;
        end
    end

    // outputs
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign roll         = roll_reg;
    assign pitch        = pitch_reg;
    assign yaw          = yaw_reg;
    assign throttle     = thr_reg;
    assign aux_flags    = aux_reg;
    assign aux_changed  = aux_chg_reg;
    assign bind_address = addr_reg;
    assign hop_channels = hop_reg;
    assign telemetry_on = tlm_reg;

`ifndef ASSERT_OFF
    // byte position never runs past the last byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("byte position out of range");

    // telemetry mode is sticky once a bind sets it
    a_tlm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        tlm_reg |=> tlm_reg)
        else $error("telemetry mode cleared");

    // stick and aux fields are zero unless a valid control packet
    a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_CONTROL) |->
            (roll == '0 && pitch == '0 && yaw == '0 && throttle == '0 &&
             aux_flags == '0 && aux_changed == '0))
        else $error("control fields set on non-control result");

    // bind fields are zero unless a bind was accepted
    a_bind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_BIND_OK) |->
            (bind_address == '0 && hop_channels == '0))
        else $error("bind fields set on non-bind result");

    // a bind result only comes while still in bind mode, and leaves it
    a_bind_leave: assert property (@(posedge clk) disable iff (!rst_n)
        emit && status_next == ST_BIND_OK |=> !bind_pending_reg)
        else $error("bind accepted but bind mode kept");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the rc receive packet decoder. A class holds a cycle-free
// model of the decoder: it tracks byte position, running sum, held bytes,
// bind state and aux history, and queues the result that each final byte
// should give. A short directed phase covers bind mode, restarts, wrap
// without packet_start, stick extremes and every status. After that, random
// control packets with noise, cut packets, bad headers and bad checksums are
// sent, while both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rcrx_pkg::*;

    localparam int          CLK_PERIOD      = 4;
    localparam int          RESET_CYCLES    = 7;
    localparam int          PKT_LEN         = 15;
    localparam int unsigned ITEM_TARGET     = 840;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          QUIET_LIMIT     = 4000;
    localparam int          DRAIN_CYCLES    = 10;

    typedef byte_t pkt_t [PKT_LEN];

    typedef enum int {PK_GOOD, PK_BAD_SUM, PK_BAD_HDR, PK_CUT, PK_NOISE} pkt_kind_t;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    // one decoded result, as seen on the output channel
    typedef struct packed {
        status_t             status;
        logic [STICK_W-1:0]  roll;
        logic [STICK_W-1:0]  pitch;
        logic [STICK_W-1:0]  yaw;
        logic [STICK_W-1:0]  throttle;
        logic [AUX_W-1:0]    aux_flags;
        logic [AUX_W-1:0]    aux_changed;
        logic [ADDR_W-1:0]   bind_address;
        logic [HOP_W-1:0]    hop_channels;
        logic                telemetry_on;
    } result_t;

    // ------------------------------------------------------------------------
    // decoder model and result checker
    // ------------------------------------------------------------------------
    class rcrx_scoreboard;
        byte_t            held [HELD_COUNT];
        logic [POS_W-1:0] pos;
        byte_t            sum;
        bit               bind_wait;
        bit               tlm_mode;
        logic [AUX_W-1:0] last_aux;
        result_t          expected_q [$];
        int unsigned      n_checked;
        int unsigned      n_errors;
        int unsigned      status_seen [5];

        function new();
            foreach (held[i])
                held[i] = '0;
            pos       = '0;
            sum       = '0;
            bind_wait = 1'b1;
            tlm_mode  = 1'b0;
            last_aux  = '0;
            n_checked = 0;
            n_errors  = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // accepted input byte: advance the model, queue a result on the last byte
        function void note_byte(byte_t b, logic start);
            logic [POS_W-1:0] p;
            logic [AUX_W-1:0] flags;
            result_t          r;
            if (start)
            begin
                pos = '0;
                sum = '0;
            end
            p = pos;
            if (p < HELD_COUNT)
                held[p] = b;
            if (p < LAST_POS)
            begin
                sum = sum + b;
                pos = p + 1'b1;
                return;
            end
            pos = '0;
            r   = '0;
            if (bind_wait)
            begin
                // bind packets skip the checksum
                if (held[0] == HDR_BIND || held[0] == HDR_BIND_TLM)
                begin
                    r.bind_address = {held[5], held[4], held[3], held[2], held[1]};
                    r.hop_channels = {held[9], held[8], held[7], held[6]};
                    if (held[0] == HDR_BIND_TLM)
                        tlm_mode = 1'b1;
                    bind_wait = 1'b0;
                    r.status  = ST_BIND_OK;
                end
                else
                    r.status = ST_BIND_SKIP;
            end
            else if (held[0] != HDR_CONTROL)
                r.status = ST_BAD_HDR;
            else if (sum != b)
                r.status = ST_BAD_SUM;
            else
            begin
                flags = {held[1] == EXPERT_MARK, held[3][7], held[2][5], held[2][4],
                         held[2][3], held[2][1], held[2][0]};
                r.status      = ST_CONTROL;
                r.roll        = {held[4][1:0], held[5]} - STICK_CENTER;
                r.pitch       = {held[6][1:0], held[7]} - STICK_CENTER;
                r.yaw         = {held[10][1:0], held[11]} - STICK_CENTER;
                r.throttle    = {held[8][1:0], held[9]};
                r.aux_flags   = flags;
                r.aux_changed = flags ^ last_aux;
                last_aux      = flags;
            end
            r.telemetry_on = tlm_mode;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [63:0] exp, logic [63:0] act);
            if (act !== exp)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp, act);
                n_errors++;
            end
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(result_t got);
            result_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, actual status %0d",
                         $time, got.status);
                n_errors++;
                return;
            end
            exp = expected_q.pop_front();
            compare_field("status",       exp.status,       got.status);
            compare_field("roll",         exp.roll,         got.roll);
            compare_field("pitch",        exp.pitch,        got.pitch);
            compare_field("yaw",          exp.yaw,          got.yaw);
            compare_field("throttle",     exp.throttle,     got.throttle);
            compare_field("aux_flags",    exp.aux_flags,    got.aux_flags);
            compare_field("aux_changed",  exp.aux_changed,  got.aux_changed);
            compare_field("bind_address", exp.bind_address, got.bind_address);
            compare_field("hop_channels", exp.hop_channels, got.hop_channels);
            compare_field("telemetry_on", exp.telemetry_on, got.telemetry_on);
            n_checked++;
            if (exp.status <= ST_BIND_SKIP)
                status_seen[exp.status]++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block under test
    // ------------------------------------------------------------------------
    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic [BYTE_W-1:0]         byte_value   = '0;
    logic                      packet_start = 1'b0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [STICK_W-1:0] roll;
    logic signed [STICK_W-1:0] pitch;
    logic signed [STICK_W-1:0] yaw;
    logic [STICK_W-1:0]        throttle;
    logic [AUX_W-1:0]          aux_flags;
    logic [AUX_W-1:0]          aux_changed;
    logic [ADDR_W-1:0]         bind_address;
    logic [HOP_W-1:0]          hop_channels;
    logic                      telemetry_on;

    rcrx_scoreboard sb = new();
    int unsigned    bytes_taken  = 0;
    int unsigned    burst_left   = 0;
    int unsigned    quiet_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    rc_rx_packet_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_value   (byte_value),
        .packet_start (packet_start),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .roll         (roll),
        .pitch        (pitch),
        .yaw          (yaw),
        .throttle     (throttle),
        .aux_flags    (aux_flags),
        .aux_changed  (aux_changed),
        .bind_address (bind_address),
        .hop_channels (hop_channels),
        .telemetry_on (telemetry_on)
    );

    // ------------------------------------------------------------------------
    // monitors: inputs feed the model first, then results are checked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_byte(byte_value, packet_start);
                bytes_taken++;
            end
            if (out_valid && out_ready)
            begin
                got.status       = status_t'(status);
                got.roll         = roll;
                got.pitch        = pitch;
                got.yaw          = yaw;
                got.throttle     = throttle;
                got.aux_flags    = aux_flags;
                got.aux_changed  = aux_changed;
                got.bind_address = bind_address;
                got.hop_channels = hop_channels;
                got.telemetry_on = telemetry_on;
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // input side: bursts of random length with random gaps
    // ------------------------------------------------------------------------
    task automatic send_byte(input byte_t b, input logic start);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 48);
        end
        in_valid     <= 1'b1;
        byte_value   <= b;
        packet_start <= start;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_packet(input pkt_t pk, input int unsigned len, input logic with_start);
        for (int unsigned i = 0; i < len; i++)
            send_byte(pk[i], (i == 0) ? with_start : 1'b0);
    endtask

    // last byte carries the sum of bytes 0..13
    function automatic void seal(inout pkt_t pk);
        byte_t s;
        s = '0;
        for (int i = 0; i < PKT_LEN - 1; i++)
            s = s + pk[i];
        pk[PKT_LEN-1] = s;
    endfunction

    // control packet with random content, broken on request
    function automatic void build_packet(output pkt_t pk, input pkt_kind_t kind);
        foreach (pk[i])
            pk[i] = byte_t'($urandom);
        pk[0] = HDR_CONTROL;
        if (kind == PK_BAD_HDR)
            while (pk[0] == HDR_CONTROL)
                pk[0] = byte_t'($urandom);
        if ($urandom_range(0, 3) == 0)
            pk[1] = EXPERT_MARK;
        seal(pk);
        if (kind == PK_BAD_SUM)
            pk[PKT_LEN-1] = pk[PKT_LEN-1] ^ byte_t'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------------
    // result side: stall patterns plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_t    mode;
        int unsigned phase;
        bit          held_off;
        phase    = 0;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held_off && sb.n_checked >= 12)
            begin
                // hold results back so the decoder backs up into its input
                held_off = 1'b1;
                @(posedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            mode = rx_mode_t'($urandom_range(0, 3));
            repeat ($urandom_range(16, 96))
            begin
                @(posedge clk);
                phase++;
                case (mode)
                    RX_OPEN:  out_ready <= 1'b1;
                    RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: out_ready <= ($urandom_range(0, 2) == 0);
                    default:  out_ready <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        pkt_t        pk;
        pkt_kind_t   kind;
        int unsigned pick;
        int unsigned items_sent;
        bit          aligned;
        items_sent = 0;
        aligned    = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // control packet while still in bind mode, no packet_start from reset
        build_packet(pk, PK_GOOD);
        send_packet(pk, PKT_LEN, 1'b0);

        // bind packet cut short, then sent again in full
        foreach (pk[i])
            pk[i] = byte_t'($urandom);
        pk[0] = ($urandom_range(0, 1) == 1) ? HDR_BIND_TLM : HDR_BIND;
        for (int i = 1; i <= 5; i++)
            pk[i] = 8'hff;
        for (int i = 6; i <= 9; i++)
            pk[i] = 8'h00;
        send_packet(pk, 6, 1'b1);
        send_packet(pk, PKT_LEN, 1'b1);

        // a bind header after binding is a bad header
        send_packet(pk, PKT_LEN, 1'b1);

        // all ones: sticks at maximum, every aux flag set
        foreach (pk[i])
            pk[i] = 8'hff;
        pk[0] = HDR_CONTROL;
        pk[1] = EXPERT_MARK;
        seal(pk);
        send_packet(pk, PKT_LEN, 1'b1);

        // all zeros: sticks at minimum, every aux flag cleared; wraps without start
        foreach (pk[i])
            pk[i] = 8'h00;
        pk[0] = HDR_CONTROL;
        seal(pk);
        send_packet(pk, PKT_LEN, 1'b0);

        // sticks centered, throttle at half
        pk[4]  = 8'h02;
        pk[6]  = 8'h02;
        pk[8]  = 8'h02;
        pk[10] = 8'h02;
        seal(pk);
        send_packet(pk, PKT_LEN, 1'b1);

        // checksum failure
        build_packet(pk, PK_BAD_SUM);
        send_packet(pk, PKT_LEN, 1'b1);

        // random traffic: mostly good control packets, some broken ones
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                kind = PK_GOOD;
            else if (pick < 80)
                kind = PK_BAD_SUM;
            else if (pick < 87)
                kind = PK_BAD_HDR;
            else if (pick < 94)
                kind = PK_CUT;
            else
                kind = PK_NOISE;
            if (kind == PK_NOISE)
            begin
                repeat ($urandom_range(1, 20))
                    send_byte(byte_t'($urandom), ($urandom_range(0, 7) == 0));
                aligned = 1'b0;
            end
            else
            begin
                build_packet(pk, kind);
                if (kind == PK_CUT)
                begin
                    send_packet(pk, $urandom_range(1, PKT_LEN - 1), 1'b1);
                    aligned = 1'b0;
                end
                else
                begin
                    send_packet(pk, PKT_LEN, !aligned || ($urandom_range(0, 4) != 0));
                    items_sent += PKT_LEN;
                    aligned = 1'b1;
                end
            end
        end
        in_valid <= 1'b0;

        // drain outstanding results, then allow for pipeline latency
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d bytes in, %0d results checked, %0d errors",
                 bytes_taken, sb.n_checked, sb.n_errors);
        $display("summary: control %0d, bad header %0d, bad checksum %0d, bind %0d, skipped %0d",
                 sb.status_seen[ST_CONTROL], sb.status_seen[ST_BAD_HDR],
                 sb.status_seen[ST_BAD_SUM], sb.status_seen[ST_BIND_OK],
                 sb.status_seen[ST_BIND_SKIP]);
        if (sb.n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
